// File: sv/blfp_pkg.sv
`default_nettype none

package blfp_pkg;

    localparam int COUNT_BITS_DEF = 8;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int DUTY_W    = 8;
    localparam int PROD_W    = 2 * DUTY_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 1'b1;

    localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd157;
    localparam logic [CFG_W-1:0] STEPS_RESET  = 8'd100;
    localparam logic [CFG_W-1:0] PERIOD_MIN   = 8'd2;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BRIGHT = 2'd1,
        MODE_HELD   = 2'd2,
        MODE_DIM    = 2'd3
    } mode_t;

    typedef struct packed {
        logic load_btn;
        logic res_held;
        logic res_idle;
        logic clear_was;
        logic start_bright;
        logic start_dim;
        logic mul;
        logic div_step;
        logic ramp_tick;
        logic out_load;
    } blfp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  btn;
        logic  was;
        logic  steps_gt1;
        logic  div_last;
        logic  new_step;
    } blfp_status_t;

endpackage

`default_nettype wire

// File: sv/blfp_dp.sv
`default_nettype none

module blfp_dp #(
    parameter int COUNT_BITS = blfp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [blfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [blfp_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               button_pressed,
    input  wire blfp_pkg::blfp_cmd_t                cmd,
    output blfp_pkg::blfp_status_t                  st,
    output logic                                    led_on,
    output logic [1:0]                              mode
);
    import blfp_pkg::*;

    localparam int CNT_W = COUNT_BITS + 1;

    logic [CFG_W-1:0]     period_reg, period_next;
    logic [CFG_W-1:0]     steps_reg, steps_next;
    mode_t                mode_reg, mode_next;
    logic                 was_reg, was_next;
    logic [DUTY_W-1:0]    step_reg, step_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic                 lit_reg, lit_next;
    logic [CNT_W-1:0]     tick_reg, tick_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 btn_reg, btn_next;
    logic [PROD_W-1:0]    quot_reg, quot_next;
    logic [DUTY_W-1:0]    rem_reg, rem_next;
    logic                 res_led_reg, res_led_next;
    mode_t                res_mode_reg, res_mode_next;
    logic                 led_reg, led_next;
    mode_t                omode_reg, omode_next;

    logic [CFG_W-1:0]     eff_period;
    logic [CFG_W-1:0]     eff_steps;
    logic [DUTY_W-1:0]    rest;
    logic [DUTY_W-1:0]    pause_val;
    logic [COUNT_BITS-1:0] pause_masked;
    logic [CNT_W-1:0]     half_len;
    logic [CNT_W-1:0]     tick_inc;
    logic                 boundary;
    logic                 last_step;
    logic [DUTY_W:0]      rem_sh;
    logic                 rem_ge;
    logic [DUTY_W:0]      rem_sub;
    logic [PROD_W-1:0]    quot_sh;

    assign eff_period = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
    assign eff_steps  = (steps_reg == '0) ? CFG_W'(1) : steps_reg;

    // pause length: lit half of a brightening step and dark half of a dimming step use duty
    assign rest      = (eff_period > duty_reg) ? (eff_period - duty_reg) : '0;
    assign pause_val = (lit_reg == (mode_reg == MODE_BRIGHT)) ? duty_reg : rest;
    assign pause_masked = COUNT_BITS'(pause_val);
    assign half_len  = CNT_W'(pause_masked) + CNT_W'(1);
    assign tick_inc  = tick_reg + CNT_W'(1);
    assign boundary  = (tick_inc >= half_len);
    assign last_step = ({1'b0, step_reg} + 9'd1) >= {1'b0, eff_steps};

    // restoring divider, one quotient bit a cycle
    assign rem_sh  = {rem_reg, quot_reg[PROD_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, eff_steps});
    assign rem_sub = rem_ge ? (rem_sh - {1'b0, eff_steps}) : rem_sh;
    assign quot_sh = {quot_reg[PROD_W-2:0], rem_ge};

    always_comb
    begin
        period_next   = period_reg;
        steps_next    = steps_reg;
        mode_next     = mode_reg;
        was_next      = was_reg;
        step_next     = step_reg;
        duty_next     = duty_reg;
        lit_next      = lit_reg;
        tick_next     = tick_reg;
        div_cnt_next  = div_cnt_reg;
        btn_next      = btn_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        res_led_next  = res_led_reg;
        res_mode_next = res_mode_reg;
        led_next      = led_reg;
        omode_next    = omode_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD: period_next = cfg_data;
                REG_STEPS:  steps_next  = cfg_data;
                default:    ;
            endcase
        end

        if (cmd.load_btn)
            btn_next = button_pressed;

        if (cmd.res_held)
        begin
            res_led_next  = 1'b1;
            res_mode_next = MODE_HELD;
        end

        if (cmd.res_idle)
        begin
            res_led_next  = 1'b0;
            res_mode_next = MODE_IDLE;
            mode_next     = MODE_IDLE;
        end

        if (cmd.clear_was)
            was_next = 1'b0;

        if (cmd.start_bright || cmd.start_dim)
        begin
            mode_next = cmd.start_dim ? MODE_DIM : MODE_BRIGHT;
            step_next = cmd.start_dim ? DUTY_W'(1) : '0;
            was_next  = cmd.start_bright;
            lit_next  = 1'b1;
            tick_next = '0;
        end

        if (cmd.mul)
        begin
            quot_next    = PROD_W'(step_reg) * PROD_W'(eff_period - CFG_W'(1));
            rem_next     = '0;
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            quot_next    = quot_sh;
            rem_next     = rem_sub[DUTY_W-1:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            if (st.div_last)
                duty_next = quot_sh[DUTY_W-1:0] + DUTY_W'(1);
        end

        if (cmd.ramp_tick)
        begin
            res_led_next  = lit_reg;
            res_mode_next = mode_reg;
            if (boundary)
            begin
                tick_next = '0;
                if (lit_reg)
                    lit_next = 1'b0;
                else if (last_step)
                    mode_next = (mode_reg == MODE_BRIGHT) ? MODE_HELD : MODE_IDLE;
                else
                begin
                    step_next = step_reg + DUTY_W'(1);
                    lit_next  = 1'b1;
                end
            end
            else
                tick_next = tick_inc;
        end

        if (cmd.out_load)
        begin
            led_next   = res_led_reg;
            omode_next = res_mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RESET;
            steps_reg   <= STEPS_RESET;
            mode_reg    <= MODE_IDLE;
            was_reg     <= 1'b0;
            step_reg    <= '0;
            duty_reg    <= '0;
            lit_reg     <= 1'b0;
            tick_reg    <= '0;
            div_cnt_reg <= '0;
            led_reg     <= 1'b0;
            omode_reg   <= MODE_IDLE;
        end
        else
        begin
            period_reg  <= period_next;
            steps_reg   <= steps_next;
            mode_reg    <= mode_next;
            was_reg     <= was_next;
            step_reg    <= step_next;
            duty_reg    <= duty_next;
            lit_reg     <= lit_next;
            tick_reg    <= tick_next;
            div_cnt_reg <= div_cnt_next;
            led_reg     <= led_next;
            omode_reg   <= omode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        btn_reg      <= btn_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        res_led_reg  <= res_led_next;
        res_mode_reg <= res_mode_next;
    end

    assign st.mode      = mode_reg;
    assign st.btn       = btn_reg;
    assign st.was       = was_reg;
    assign st.steps_gt1 = (eff_steps > CFG_W'(1));
    assign st.div_last  = (div_cnt_reg == DIV_CNT_W'(PROD_W - 1));
    assign st.new_step  = boundary && !lit_reg && !last_step;

    assign led_on = led_reg;
    assign mode   = omode_reg;

    a_dark_outside_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE || mode_reg == MODE_HELD) |-> !lit_reg)
        else $error("lit half flag set outside a ramp");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg < CNT_W'(256))
        else $error("pause counter beyond longest pause");

endmodule

`default_nettype wire

// File: sv/blfp_ctrl.sv
`default_nettype none

module blfp_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    input  wire blfp_pkg::blfp_status_t  st,
    output blfp_pkg::blfp_cmd_t          cmd
);
    import blfp_pkg::*;

    typedef enum logic [5:0] {
        S_READY = 6'b000001,
        S_EVAL  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_RAMP  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   to_ramp_reg, to_ramp_next;   // after the divide: ramp tick (start) or output (step)
    logic   ovalid_reg, ovalid_next;
    logic   in_take;
    logic   out_free;

    assign in_stall = (state_reg != S_READY);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        to_ramp_next = to_ramp_reg;
        ovalid_next  = ovalid_reg && out_stall;

        case (state_reg)
            S_READY:
            begin
                if (in_take)
                begin
                    cmd.load_btn = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.mode == MODE_HELD)
                begin
                    cmd.res_held = st.btn;
                    cmd.res_idle = !st.btn;
                    state_next   = S_OUT;
                end
                else if (st.mode == MODE_IDLE)
                begin
                    if (st.btn)
                    begin
                        cmd.start_bright = 1'b1;
                        to_ramp_next     = 1'b1;
                        state_next       = S_MUL;
                    end
                    else if (st.was && st.steps_gt1)
                    begin
                        cmd.start_dim = 1'b1;
                        to_ramp_next  = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        cmd.res_idle  = 1'b1;
                        cmd.clear_was = 1'b1;
                        state_next    = S_OUT;
                    end
                end
                else
                    state_next = S_RAMP;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = to_ramp_reg ? S_RAMP : S_OUT;
            end
            S_RAMP:
            begin
                cmd.ramp_tick = 1'b1;
                if (st.new_step)
                begin
                    to_ramp_next = 1'b0;
                    state_next   = S_MUL;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_READY;
                end
            end
            default:
                state_next = S_READY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_READY;
            to_ramp_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            to_ramp_reg <= to_ramp_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_EVAL))
        else $error("request accepted but not evaluated");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && st.div_last) |=> (state_reg == S_RAMP || state_reg == S_OUT))
        else $error("divide did not finish to ramp or output");

endmodule

`default_nettype wire

// File: sv/button_led_fade_pwm_top.sv
// Button driven LED fade, one request per prescaled tick.
// An idle or held tick is evaluated and registered; a plain ramp tick adds the ramp
// update; a ramp start adds an 8x8 multiply and a 16-bit restoring divide for the
// duty before the update, a new step after it. No request is taken until output.
// Reset: idle, LED off, period 157 and 100 ramp steps; no clearing pass.
`default_nettype none

module button_led_fade_pwm_top #(
    parameter int COUNT_BITS = blfp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [blfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [blfp_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           button_pressed,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                led_on,
    output logic [1:0]                          mode
);
    import blfp_pkg::*;

    blfp_cmd_t    cmd;
    blfp_status_t st;

    blfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    blfp_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .button_pressed (button_pressed),
        .cmd            (cmd),
        .st             (st),
        .led_on         (led_on),
        .mode           (mode)
    );

endmodule

`default_nettype wire
